>>> design/pcur_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcur_pkg
// types, command codes and the control store of the paged list cursor
// ----------------------------------------------------------------------------
package pcur_pkg;

   // command codes
   localparam logic [1:0] CMD_TURN  = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_START = 2'd2;
   localparam logic [1:0] CMD_SET   = 2'd3;

   // register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAGE_SIZE   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOTAL_ITEMS = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        direction;
      logic        force_move;
      logic        clear_first;
      logic [15:0] new_index;
      logic        track_page;
   } req_word_type;

   typedef struct packed {
      logic [15:0] page_now;
      logic [15:0] index_now;
      logic        page_changed;
      logic        item_moved;
   } rsp_word_type;

   // micro-operations
   localparam int unsigned OP_WIDTH = 4;
   localparam logic [OP_WIDTH-1:0] OP_NOP        = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_TURN_PREP  = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_TURN_APPLY = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_STEP_MOVE  = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_DIV_INDEX  = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_STEP_CHECK = 4'd5;
   localparam logic [OP_WIDTH-1:0] OP_EMIT       = 4'd6;
   localparam logic [OP_WIDTH-1:0] OP_START      = 4'd7;
   localparam logic [OP_WIDTH-1:0] OP_SET_FIRST  = 4'd8;
   localparam logic [OP_WIDTH-1:0] OP_SET_MID    = 4'd9;
   localparam logic [OP_WIDTH-1:0] OP_SET_FINAL  = 4'd10;

   // sequencing conditions
   localparam logic [1:0] COND_NEXT = 2'd0;   // fall through
   localparam logic [1:0] COND_JUMP = 2'd1;   // always jump
   localparam logic [1:0] COND_TEST = 2'd2;   // jump when the datapath test is set
   localparam logic [1:0] COND_DIV  = 2'd3;   // jump while the divider runs

   localparam int unsigned PC_WIDTH = 4;

   // program addresses
   localparam logic [PC_WIDTH-1:0] PC_TURN      = 4'd0;
   localparam logic [PC_WIDTH-1:0] PC_TURN_WAIT = 4'd1;
   localparam logic [PC_WIDTH-1:0] PC_STEP      = 4'd3;
   localparam logic [PC_WIDTH-1:0] PC_STEP_WAIT = 4'd5;
   localparam logic [PC_WIDTH-1:0] PC_EMIT      = 4'd7;
   localparam logic [PC_WIDTH-1:0] PC_START     = 4'd8;
   localparam logic [PC_WIDTH-1:0] PC_SET       = 4'd9;
   localparam logic [PC_WIDTH-1:0] PC_SET_WAIT1 = 4'd10;
   localparam logic [PC_WIDTH-1:0] PC_SET_WAIT2 = 4'd12;

   typedef struct packed {
      logic [OP_WIDTH-1:0] op;
      logic [1:0]          cond;
      logic [PC_WIDTH-1:0] target;
   } ucode_type;

   function automatic ucode_type make_uword(logic [OP_WIDTH-1:0] op, logic [1:0] cond,
                                            logic [PC_WIDTH-1:0] target);
      ucode_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // control store
   function automatic ucode_type ucode_rom(logic [PC_WIDTH-1:0] pc);
      ucode_type w;
      case (pc)
         4'd0:    w = make_uword(OP_TURN_PREP,  COND_TEST, PC_EMIT);
         4'd1:    w = make_uword(OP_NOP,        COND_DIV,  PC_TURN_WAIT);
         4'd2:    w = make_uword(OP_TURN_APPLY, COND_JUMP, PC_EMIT);
         4'd3:    w = make_uword(OP_STEP_MOVE,  COND_TEST, PC_EMIT);
         4'd4:    w = make_uword(OP_DIV_INDEX,  COND_NEXT, PC_EMIT);
         4'd5:    w = make_uword(OP_NOP,        COND_DIV,  PC_STEP_WAIT);
         4'd6:    w = make_uword(OP_STEP_CHECK, COND_TEST, PC_TURN);
         4'd7:    w = make_uword(OP_EMIT,       COND_TEST, PC_EMIT);
         4'd8:    w = make_uword(OP_START,      COND_JUMP, PC_EMIT);
         4'd9:    w = make_uword(OP_SET_FIRST,  COND_TEST, PC_EMIT);
         4'd10:   w = make_uword(OP_NOP,        COND_DIV,  PC_SET_WAIT1);
         4'd11:   w = make_uword(OP_SET_MID,    COND_NEXT, PC_EMIT);
         4'd12:   w = make_uword(OP_NOP,        COND_DIV,  PC_SET_WAIT2);
         4'd13:   w = make_uword(OP_SET_FINAL,  COND_JUMP, PC_EMIT);
         default: w = make_uword(OP_NOP,        COND_JUMP, PC_EMIT);
      endcase
      return w;
   endfunction

   // program entry for each command
   function automatic logic [PC_WIDTH-1:0] entry_pc(logic [1:0] cmd);
      logic [PC_WIDTH-1:0] pc;
      unique case (cmd)
         CMD_TURN:  pc = PC_TURN;
         CMD_STEP:  pc = PC_STEP;
         CMD_START: pc = PC_START;
         CMD_SET:   pc = PC_SET;
         default:   pc = PC_EMIT;
      endcase
      return pc;
   endfunction

endpackage

>>> design/paged_list_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paged_list_cursor
// cursor over a paged list: current page, current index, sticky change flags
// ----------------------------------------------------------------------------
// req channel carries one command word (turn page, step item, go to start,
// set index); rsp returns exactly one word per command: page, index and the
// two sticky flags after the command. csr writes page_size (index 0, zero
// acts as one) and total_items (index 1); the user must write them only
// while no command is in flight: the block itself does not enforce this.
// a small microprogram runs each command; page counts, page offsets and page
// numbers come from one shared restoring divider, one quotient bit per cycle
// over DW = max(INDEX_WIDTH,16)+1 bits. go to start and plain set index need
// no division, turn page needs one (none on an empty list), step item one
// (two with a page turn, none when blocked), tracked set index two. a new
// word is taken the cycle after the previous result is registered.
// synchronous reset: cursor at page 0 / index 0, flags clear, page_size 1,
// total_items 0, no result pending. while rsp_stall is high the result holds
// in the output register; the next command runs and waits at its final step.
// ----------------------------------------------------------------------------
module paged_list_cursor
   import pcur_pkg::*;
#(
   parameter int unsigned INDEX_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   // command channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_word_type               req_word,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_word_type               rsp_word,
   // register writes
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // datapath width: holds any index, page count numerator or sum of index and page size
   localparam int unsigned DW = ((INDEX_WIDTH > 16) ? INDEX_WIDTH : 16) + 1;
   localparam int unsigned CW = $clog2(DW + 1);
   localparam int unsigned IW = INDEX_WIDTH;

   // configuration registers
   logic [15:0] page_size_ff;
   logic [15:0] total_items_ff;

   // cursor state
   logic [IW-1:0] page_ff, page_in;
   logic [IW-1:0] index_ff, index_in;
   logic          flag_page_ff, flag_page_in;
   logic          flag_item_ff, flag_item_in;
   logic [IW-1:0] prior_page_ff, prior_page_in;

   // sequencer
   logic                busy_ff, busy_in;
   logic [PC_WIDTH-1:0] pc_ff, pc_in;
   ucode_type           uword;
   logic                test;

   // latched command
   logic        direction_ff, direction_in;
   logic        force_ff, force_in;
   logic        clear_ff, clear_in;
   logic [15:0] new_index_ff, new_index_in;
   logic        track_ff, track_in;

   // divider
   logic [DW-1:0] div_quo_ff, div_quo_in;
   logic [16:0]   div_rem_ff, div_rem_in;
   logic [CW-1:0] div_cnt_ff, div_cnt_in;
   logic          div_start;
   logic [DW-1:0] div_dividend;
   logic          div_busy;
   logic [16:0]   div_shift;
   logic [17:0]   div_diff;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // shared arithmetic
   logic [15:0]   eps;
   logic [DW-1:0] eps_ext, total_ext, page_ext, index_ext, new_ext;
   logic [DW-1:0] pages_num, last_ext, page_inc, idx_inc, idx_plus_ps, idx_minus_ps;
   logic [IW-1:0] new_trunc;
   logic          list_empty;

   assign eps          = (page_size_ff == 16'd0) ? 16'd1 : page_size_ff;
   assign eps_ext      = DW'(eps);
   assign total_ext    = DW'(total_items_ff);
   assign page_ext     = DW'(page_ff);
   assign index_ext    = DW'(index_ff);
   assign new_ext      = DW'(new_index_ff);
   assign new_trunc    = new_ext[IW-1:0];
   assign pages_num    = total_ext + eps_ext - DW'(1);
   assign last_ext     = total_ext - DW'(1);
   assign page_inc     = page_ext + DW'(1);
   assign idx_inc      = index_ext + DW'(1);
   assign idx_plus_ps  = index_ext + eps_ext;
   assign idx_minus_ps = index_ext - eps_ext;
   assign list_empty   = (total_items_ff == 16'd0);

   assign uword     = ucode_rom(pc_ff);
   assign div_busy  = (div_cnt_ff != '0);
   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // datapath actions of the current control word
   always_comb begin
      page_in       = page_ff;
      index_in      = index_ff;
      flag_page_in  = flag_page_ff;
      flag_item_in  = flag_item_ff;
      prior_page_in = prior_page_ff;
      force_in      = force_ff;
      clear_in      = clear_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_word_in   = rsp_word_ff;
      div_start     = 1'b0;
      div_dividend  = index_ext;
      test          = 1'b0;

      if (busy_ff) begin
         unique case (uword.op)
            OP_NOP: begin
            end
            OP_TURN_PREP: begin
               // optional flag clear, then page count = ceil(total / size)
               if (clear_ff) begin
                  flag_page_in = 1'b0;
                  flag_item_in = 1'b0;
               end
               test = list_empty;
               if (!list_empty) begin
                  div_start    = 1'b1;
                  div_dividend = pages_num;
               end
            end
            OP_TURN_APPLY: begin
               if (direction_ff) begin
                  if (page_inc < div_quo_ff) begin
                     page_in      = page_inc[IW-1:0];
                     flag_page_in = 1'b1;
                     if (force_ff) begin
                        index_in     = (idx_plus_ps >= total_ext) ? last_ext[IW-1:0]
                                                                  : idx_plus_ps[IW-1:0];
                        flag_item_in = 1'b1;
                     end
                  end else if (index_ext != last_ext) begin
                     // already on the last page: jump to the last item
                     index_in     = last_ext[IW-1:0];
                     flag_item_in = 1'b1;
                  end
               end else begin
                  if (page_ff != '0) begin
                     page_in      = page_ff - IW'(1);
                     flag_page_in = 1'b1;
                     if (force_ff) begin
                        // saturate at the first item
                        index_in     = (index_ext > eps_ext) ? idx_minus_ps[IW-1:0] : '0;
                        flag_item_in = 1'b1;
                     end
                  end else if (index_ff != '0) begin
                     index_in     = '0;
                     flag_item_in = 1'b1;
                  end
               end
            end
            OP_STEP_MOVE: begin
               flag_page_in = 1'b0;
               flag_item_in = 1'b0;
               if (list_empty) begin
                  test = 1'b1;
               end else if (direction_ff) begin
                  if (idx_inc >= total_ext) begin
                     test = 1'b1;
                  end else begin
                     index_in     = idx_inc[IW-1:0];
                     flag_item_in = 1'b1;
                  end
               end else begin
                  if (index_ff == '0) begin
                     test = 1'b1;
                  end else begin
                     index_in     = index_ff - IW'(1);
                     flag_item_in = 1'b1;
                  end
               end
            end
            OP_DIV_INDEX: begin
               div_start    = 1'b1;
               div_dividend = index_ext;
            end
            OP_STEP_CHECK: begin
               // crossed a page boundary: run a plain page turn
               if (direction_ff) begin
                  test = (div_rem_ff == 17'd0);
               end else begin
                  test = (div_rem_ff == ({1'b0, eps} - 17'd1));
               end
               if (test) begin
                  force_in = 1'b0;
                  clear_in = 1'b0;
               end
            end
            OP_EMIT: begin
               test = rsp_valid_ff & rsp_stall;
               if (!test) begin
                  rsp_valid_in             = 1'b1;
                  rsp_word_in.page_now     = page_ext[15:0];
                  rsp_word_in.index_now    = index_ext[15:0];
                  rsp_word_in.page_changed = flag_page_ff;
                  rsp_word_in.item_moved   = flag_item_ff;
                  busy_in                  = 1'b0;
               end
            end
            OP_START: begin
               flag_page_in = (page_ff != '0);
               flag_item_in = (index_ff != '0);
               page_in      = '0;
               index_in     = '0;
            end
            OP_SET_FIRST: begin
               test = !track_ff;
               if (!track_ff) begin
                  index_in = new_trunc;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = index_ext;
               end
            end
            OP_SET_MID: begin
               prior_page_in = div_quo_ff[IW-1:0];
               div_start     = 1'b1;
               div_dividend  = DW'(new_trunc);
            end
            OP_SET_FINAL: begin
               if (index_ff != new_trunc) begin
                  flag_item_in = 1'b1;
               end
               if (prior_page_ff != div_quo_ff[IW-1:0]) begin
                  flag_page_in = 1'b1;
               end
               index_in = new_trunc;
               page_in  = div_quo_ff[IW-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer: step counter with conditional jumps, dispatch on accept
   always_comb begin
      pc_in        = pc_ff;
      direction_in = direction_ff;
      new_index_in = new_index_ff;
      track_in     = track_ff;
      if (busy_ff) begin
         unique case (uword.cond)
            COND_NEXT: pc_in = pc_ff + PC_WIDTH'(1);
            COND_JUMP: pc_in = uword.target;
            COND_TEST: pc_in = test ? uword.target : pc_ff + PC_WIDTH'(1);
            COND_DIV:  pc_in = div_busy ? uword.target : pc_ff + PC_WIDTH'(1);
            default:   pc_in = uword.target;
         endcase
      end else if (req_valid) begin
         pc_in        = entry_pc(req_word.cmd);
         direction_in = req_word.direction;
         new_index_in = req_word.new_index;
         track_in     = req_word.track_page;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign div_shift = {div_rem_ff[15:0], div_quo_ff[DW-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, eps};

   always_comb begin
      div_quo_in = div_quo_ff;
      div_rem_in = div_rem_ff;
      div_cnt_in = div_cnt_ff;
      if (div_start) begin
         div_quo_in = div_dividend;
         div_rem_in = '0;
         div_cnt_in = CW'(DW);
      end else if (div_busy) begin
         div_quo_in = {div_quo_ff[DW-2:0], ~div_diff[17]};
         div_rem_in = div_diff[17] ? div_shift : div_diff[16:0];
         div_cnt_in = div_cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff   <= 16'd1;
         total_items_ff <= 16'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PAGE_SIZE:   page_size_ff   <= csr_wdata;
            CSR_TOTAL_ITEMS: total_items_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff      <= '0;
         index_ff     <= '0;
         flag_page_ff <= 1'b0;
         flag_item_ff <= 1'b0;
         busy_ff      <= 1'b0;
         pc_ff        <= PC_EMIT;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         page_ff      <= page_in;
         index_ff     <= index_in;
         flag_page_ff <= flag_page_in;
         flag_item_ff <= flag_item_in;
         busy_ff      <= busy_in | (!busy_ff & req_valid);
         pc_ff        <= pc_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      prior_page_ff <= prior_page_in;
      direction_ff  <= direction_in;
      new_index_ff  <= new_index_in;
      track_ff      <= track_in;
      div_quo_ff    <= div_quo_in;
      div_rem_ff    <= div_rem_in;
      rsp_word_ff   <= rsp_word_in;
      if (!busy_ff && req_valid) begin
         force_ff <= req_word.force_move;
         clear_ff <= req_word.clear_first;
      end else begin
         force_ff <= force_in;
         clear_ff <= clear_in;
      end
   end

   // checks
   a_div_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> busy_ff)
      else $error("divider running with no command in flight");

   a_accept_starts_program: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (busy_ff && pc_ff == entry_pc($past(req_word.cmd))))
      else $error("accepted command did not enter its program");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(busy_ff) && !busy_ff))
      else $error("result appeared outside the emit step");

   a_wait_step_has_divider: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && uword.cond == COND_DIV) |-> $past(div_start || div_busy))
      else $error("divider wait step reached without a division");

endmodule
